[src/pair_hash_table_defines.svh]
// Assertion macros for the pair hash table checker.
`ifndef PAIR_HASH_TABLE_DEFINES_SVH
`define PAIR_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define PHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pair hash table check failed");

// Next-cycle implication, quiet during reset
`define PHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pair hash table check failed");

`endif

[src/pht_pkg.sv]
// Package of the pair hash table: codes, widths and hash step helpers.
package pht_pkg;

  localparam int DEFAULT_CAPACITY = 1024;
  localparam int KEY_W            = 32;
  localparam int ID_W             = 16;
  localparam int WORD_W           = 32;
  localparam int FUNC_W           = 2;
  localparam int IDX_OUT_W        = 10;
  localparam int CNT_OUT_W        = 11;
  localparam int IN_TDATA_W       = 72;
  localparam int OUT_TDATA_W      = 56;

  // Operation codes carried on the input tuser
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Mixer steps: even steps add a left shift (inverted, except on the plain step), odd steps xor a right shift
  localparam logic [2:0] HASH_STEP_PLAIN = 3'd2;
  localparam logic [2:0] HASH_LAST_STEP  = 3'd5;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  // Shift distance of each mixer step
  function automatic logic [4:0] mix_shift(input logic [2:0] step);
    logic [4:0] sh;
    unique case (step)
      3'd0:    sh = 5'd15;
      3'd1:    sh = 5'd10;
      3'd2:    sh = 5'd3;
      3'd3:    sh = 5'd6;
      3'd4:    sh = 5'd11;
      3'd5:    sh = 5'd16;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

endpackage

[src/pht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pht_hash.sv]
// Iterative 32-bit integer mixer: one shift-and-combine step per cycle.
module pht_hash (
  input  logic                     clk,
  input  logic                     rst,
  input  pht_pkg::hash_req_t       req,
  output logic                     done,
  output logic [pht_pkg::KEY_W-1:0] result
);

  logic                      busy;
  logic [2:0]                step;
  logic [pht_pkg::KEY_W-1:0] operand;
  logic [pht_pkg::KEY_W-1:0] k_next;
  logic [4:0]                sh;

  // Shared shift, invert and add-or-xor unit
  always_comb begin
    sh = pht_pkg::mix_shift(step);
    if (step[0]) begin
      operand = result >> sh;
      k_next  = result ^ operand;
    end else begin
      operand = result << sh;
      if (step != pht_pkg::HASH_STEP_PLAIN) begin
        operand = ~operand;
      end
      k_next = result + operand;
    end
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == pht_pkg::HASH_LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Mixer value
  always_ff @(posedge clk) begin
    if (req.start) begin
      result <= req.key;
    end else if (busy) begin
      result <= k_next;
    end
  end

endmodule

[src/pair_hash_table.sv]
// Pair hash table top level: sequencer, entry stores and result register.
// One word at a time: after a word is taken the table is busy until its result
// has been taken. A find or add hashes the key and then walks its bucket's chain,
// one entry at a time; a remove that moves the last entry then also reads that
// entry, hashes its key and walks its chain. After reset the bucket store is
// cleared, one bucket a cycle, before the first word is taken.
module pair_hash_table #(
  parameter int CAPACITY = pht_pkg::DEFAULT_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // id_first [15:0], id_second [31:16], data_in [63:32], overwrite [64], zero pad
  input  logic [pht_pkg::IN_TDATA_W-1:0]  s_tdata,
  // func [1:0]
  input  logic [pht_pkg::FUNC_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit [0], table_full [1], entry_index [11:2], data_out [43:12],
  // pair_count [54:44], zero pad
  output logic [pht_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CAP   = CW'(CAPACITY);
  localparam logic [CW-1:0] EMPTY = CW'(CAPACITY);

  typedef enum logic [14:0] {
    S_CLEAR     = 15'b000000000000001,
    S_IDLE      = 15'b000000000000010,
    S_HASH      = 15'b000000000000100,
    S_HEAD      = 15'b000000000001000,
    S_LK_CHK    = 15'b000000000010000,
    S_LK_RD     = 15'b000000000100000,
    S_FINISH    = 15'b000000001000000,
    S_LAST_RD   = 15'b000000010000000,
    S_LAST_HASH = 15'b000000100000000,
    S_L_HEAD    = 15'b000001000000000,
    S_L_CHK     = 15'b000010000000000,
    S_L_RD      = 15'b000100000000000,
    S_L_LINK    = 15'b001000000000000,
    S_L_HEAD2   = 15'b010000000000000,
    S_L_MOVE    = 15'b100000000000000
  } state_t;

  state_t state;

  logic [CW-1:0] cnt;
  logic [IW-1:0] clr;
  logic          accept;

  // Latched item
  logic [pht_pkg::FUNC_W-1:0] func_r;
  logic [pht_pkg::KEY_W-1:0]  key_r;
  logic [pht_pkg::WORD_W-1:0] data_r;
  logic                       ovw_r;

  // Walk state
  logic [IW-1:0]              b;
  logic [IW-1:0]              lb;
  logic [CW-1:0]              headb;
  logic [CW-1:0]              cur;
  logic [IW-1:0]              prev;
  logic                       prev_valid;
  logic [CW-1:0]              steps;
  logic                       found;
  logic [IW-1:0]              p;
  logic [CW-1:0]              plink;
  logic [pht_pkg::WORD_W-1:0] wrd;
  logic [pht_pkg::KEY_W-1:0]  lkey;
  logic [pht_pkg::WORD_W-1:0] lword;
  logic [CW-1:0]              last_c;
  logic                       can_walk;

  // Result register
  logic                          hit_o;
  logic                          full_o;
  logic [pht_pkg::IDX_OUT_W-1:0] idx_o;
  logic [pht_pkg::WORD_W-1:0]    word_o;
  logic [pht_pkg::CNT_OUT_W-1:0] count_o;

  // Store ports
  logic                       head_we, key_we, word_we, link_we;
  logic [IW-1:0]              head_waddr, key_waddr, word_waddr, link_waddr;
  logic [CW-1:0]              head_wdata, link_wdata;
  logic [pht_pkg::KEY_W-1:0]  key_wdata;
  logic [pht_pkg::WORD_W-1:0] word_wdata;
  logic [IW-1:0]              head_raddr, kw_raddr, link_raddr;
  logic [CW-1:0]              head_rd, link_rd;
  logic [pht_pkg::KEY_W-1:0]  key_rd;
  logic [pht_pkg::WORD_W-1:0] word_rd;

  pht_pkg::hash_req_t         hreq;
  logic                       hdone;
  logic [pht_pkg::KEY_W-1:0]  hres;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign accept   = s_tvalid && s_tready;
  assign last_c   = cnt - CW'(1);
  assign can_walk = (cur < cnt) && (steps < CAP);
  assign m_tdata  = {1'b0, count_o, word_o, idx_o, full_o, hit_o};

  // Start the mixer on a new word or on the key of the last entry
  assign hreq.start = accept || (state == S_LAST_RD);
  assign hreq.key   = accept ? {s_tdata[31:16], s_tdata[15:0]} : key_rd;

  pht_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .req    (hreq),
    .done   (hdone),
    .result (hres)
  );

  pht_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );

  pht_ram #(.WIDTH(pht_pkg::KEY_W), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(kw_raddr), .rdata(key_rd)
  );

  pht_ram #(.WIDTH(pht_pkg::WORD_W), .DEPTH(CAPACITY)) u_words (
    .clk(clk), .we(word_we), .waddr(word_waddr), .wdata(word_wdata),
    .raddr(kw_raddr), .rdata(word_rd)
  );

  pht_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd)
  );

  // Store addresses and writes
  always_comb begin
    head_raddr = (state == S_L_HEAD2) ? lb : hres[IW-1:0];
    kw_raddr   = (state == S_FINISH) ? last_c[IW-1:0] : cur[IW-1:0];
    link_raddr = cur[IW-1:0];
    head_we    = 1'b0;
    key_we     = 1'b0;
    word_we    = 1'b0;
    link_we    = 1'b0;
    head_waddr = b;
    key_waddr  = p;
    word_waddr = p;
    link_waddr = prev;
    head_wdata = plink;
    key_wdata  = key_r;
    word_wdata = data_r;
    link_wdata = plink;
    unique case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr;
        head_wdata = EMPTY;
      end
      S_FINISH: begin
        if (func_r == pht_pkg::FUNC_ADD) begin
          if (found) begin
            word_we = ovw_r;
          end else if (cnt < CAP) begin
            key_we     = 1'b1;
            word_we    = 1'b1;
            link_we    = 1'b1;
            head_we    = 1'b1;
            key_waddr  = cnt[IW-1:0];
            word_waddr = cnt[IW-1:0];
            link_waddr = cnt[IW-1:0];
            link_wdata = headb;
            head_wdata = cnt;
          end
        end else if (func_r == pht_pkg::FUNC_REMOVE && found) begin
          // Unlink the hit entry from its chain
          if (prev_valid) begin
            link_we = 1'b1;
          end else begin
            head_we = 1'b1;
          end
        end
      end
      S_L_LINK: begin
        head_waddr = lb;
        head_wdata = link_rd;
        link_wdata = link_rd;
        if (prev_valid) begin
          link_we = 1'b1;
        end else begin
          head_we = 1'b1;
        end
      end
      S_L_MOVE: begin
        // Move the last entry into the hole, at the head of its chain
        key_we     = 1'b1;
        word_we    = 1'b1;
        link_we    = 1'b1;
        head_we    = 1'b1;
        key_wdata  = lkey;
        word_wdata = lword;
        link_waddr = p;
        link_wdata = head_rd;
        head_waddr = lb;
        head_wdata = CW'(p);
      end
      default: begin
      end
    endcase
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + IW'(1);
          if (clr == IW'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hdone) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: state <= S_LK_CHK;
        S_LK_CHK: begin
          state <= can_walk ? S_LK_RD : S_FINISH;
        end
        S_LK_RD: begin
          state <= (key_rd == key_r) ? S_FINISH : S_LK_CHK;
        end
        S_FINISH: begin
          if (func_r == pht_pkg::FUNC_REMOVE && found && last_c != CW'(p)) begin
            state <= S_LAST_RD;
          end else begin
            state    <= S_IDLE;
            m_tvalid <= 1'b1;
            if (func_r == pht_pkg::FUNC_ADD && !found && cnt < CAP) begin
              cnt <= cnt + CW'(1);
            end else if (func_r == pht_pkg::FUNC_REMOVE && found) begin
              cnt <= last_c;
            end
          end
        end
        S_LAST_RD: state <= S_LAST_HASH;
        S_LAST_HASH: begin
          if (hdone) begin
            state <= S_L_HEAD;
          end
        end
        S_L_HEAD: state <= S_L_CHK;
        S_L_CHK: begin
          if (cur == last_c) begin
            state <= S_L_LINK;
          end else if (can_walk) begin
            state <= S_L_RD;
          end else begin
            state <= S_L_HEAD2;
          end
        end
        S_L_RD:    state <= S_L_CHK;
        S_L_LINK:  state <= S_L_HEAD2;
        S_L_HEAD2: state <= S_L_MOVE;
        S_L_MOVE: begin
          state    <= S_IDLE;
          m_tvalid <= 1'b1;
          cnt      <= last_c;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        func_r <= s_tuser;
        key_r  <= {s_tdata[31:16], s_tdata[15:0]};
        data_r <= s_tdata[63:32];
        ovw_r  <= s_tdata[64];
        found  <= 1'b0;
      end
      S_HASH: begin
        b <= hres[IW-1:0];
      end
      S_HEAD, S_L_HEAD: begin
        headb      <= head_rd;
        cur        <= head_rd;
        prev_valid <= 1'b0;
        steps      <= '0;
      end
      S_LK_RD: begin
        if (key_rd == key_r) begin
          found <= 1'b1;
          p     <= cur[IW-1:0];
          plink <= link_rd;
          wrd   <= word_rd;
        end else begin
          prev       <= cur[IW-1:0];
          prev_valid <= 1'b1;
          cur        <= link_rd;
          steps      <= steps + CW'(1);
        end
      end
      S_L_RD: begin
        prev       <= cur[IW-1:0];
        prev_valid <= 1'b1;
        cur        <= link_rd;
        steps      <= steps + CW'(1);
      end
      S_FINISH: begin
        // An unused operation code reports no hit even when the pair is present
        hit_o   <= found && (func_r == pht_pkg::FUNC_FIND || func_r == pht_pkg::FUNC_ADD ||
                             func_r == pht_pkg::FUNC_REMOVE);
        full_o  <= 1'b0;
        idx_o   <= '0;
        word_o  <= '0;
        count_o <= pht_pkg::CNT_OUT_W'(cnt);
        if (func_r == pht_pkg::FUNC_FIND) begin
          if (found) begin
            idx_o  <= pht_pkg::IDX_OUT_W'(p);
            word_o <= wrd;
          end
        end else if (func_r == pht_pkg::FUNC_ADD) begin
          if (found) begin
            idx_o  <= pht_pkg::IDX_OUT_W'(p);
            word_o <= ovw_r ? data_r : wrd;
          end else if (cnt < CAP) begin
            idx_o   <= pht_pkg::IDX_OUT_W'(cnt);
            word_o  <= data_r;
            count_o <= pht_pkg::CNT_OUT_W'(cnt + CW'(1));
          end else begin
            full_o <= 1'b1;
          end
        end else if (func_r == pht_pkg::FUNC_REMOVE) begin
          if (found) begin
            idx_o   <= pht_pkg::IDX_OUT_W'(p);
            word_o  <= wrd;
            count_o <= pht_pkg::CNT_OUT_W'(last_c);
          end
        end
      end
      S_LAST_RD: begin
        lkey  <= key_rd;
        lword <= word_rd;
      end
      S_LAST_HASH: begin
        lb <= hres[IW-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

[src/pht_checker.sv]
// Port-level checker for the pair hash table, bound to the top level.
`include "pair_hash_table_defines.svh"

module pht_checker #(
  parameter int CAPACITY = pht_pkg::DEFAULT_CAPACITY
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pht_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // Hold a stalled result word
  `PHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Take no word while a result waits
  `PHT_ASSERT_NOW(a_one_at_a_time, m_tvalid, !s_tready)

  // Drop ready once a word is taken
  `PHT_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

  // A refused add reports no hit, index or word
  `PHT_ASSERT_NOW(a_full_clean, m_tvalid && m_tdata[1], !m_tdata[0] && m_tdata[43:2] == '0)

  // Never count past the capacity
  `PHT_ASSERT_NOW(a_count_bound, m_tvalid, 32'(m_tdata[54:44]) <= CAPACITY)

endmodule

bind pair_hash_table pht_checker #(.CAPACITY(CAPACITY)) u_pht_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
